@@ src/i2a_pkg.sv @@
package i2a_pkg;

  localparam int DEF_VALUE_WIDTH = 64;
  localparam int IN_TDATA_W      = 64;
  localparam int OUT_TDATA_W     = 8;
  localparam int CHAR_W          = 6;
  localparam int PC_W            = 3;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  // '0'..'9' are 6'b11_dddd for a BCD digit dddd
  localparam logic [1:0]        CHAR_DIGIT_HI = 2'b11;

  localparam logic [PC_W-1:0] ADDR_LOAD   = 3'd0;
  localparam logic [PC_W-1:0] ADDR_SIGN   = 3'd1;
  localparam logic [PC_W-1:0] ADDR_DABBLE = 3'd2;
  localparam logic [PC_W-1:0] ADDR_SKIP   = 3'd3;
  localparam logic [PC_W-1:0] ADDR_EMIT   = 3'd4;
  localparam logic [PC_W-1:0] ADDR_DONE   = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SIGN,
    OP_DABBLE,
    OP_SKIP,
    OP_EMIT,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_BITS_MORE,
    COND_LEAD_ZERO,
    COND_DIGITS_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] jmp;
  } cw_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic neg;
    logic out_free;
    logic bits_more;
    logic lead_zero;
    logic digits_more;
  } stat_t;

  // step issued to the datapath
  typedef struct packed {
    op_t  op;
    logic go;
  } ctrl_t;

  // microprogram: on a taken condition jump, otherwise fall through
  function automatic cw_t rom(input logic [PC_W-1:0] addr);
    cw_t cw;
    case (addr)
      ADDR_LOAD:   cw = '{op: OP_LOAD,   cond: COND_NEVER,       jmp: ADDR_LOAD};
      ADDR_SIGN:   cw = '{op: OP_SIGN,   cond: COND_NEVER,       jmp: ADDR_LOAD};
      ADDR_DABBLE: cw = '{op: OP_DABBLE, cond: COND_BITS_MORE,   jmp: ADDR_DABBLE};
      ADDR_SKIP:   cw = '{op: OP_SKIP,   cond: COND_LEAD_ZERO,   jmp: ADDR_SKIP};
      ADDR_EMIT:   cw = '{op: OP_EMIT,   cond: COND_DIGITS_MORE, jmp: ADDR_EMIT};
      ADDR_DONE:   cw = '{op: OP_NOP,    cond: COND_ALWAYS,      jmp: ADDR_LOAD};
      default:     cw = '{op: OP_NOP,    cond: COND_ALWAYS,      jmp: ADDR_LOAD};
    endcase
    return cw;
  endfunction

endpackage

@@ src/i2a_seq.sv @@
module i2a_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  i2a_pkg::stat_t stat,
  output i2a_pkg::ctrl_t ctrl
);

  logic [i2a_pkg::PC_W-1:0] pc_r, pc_nxt;
  i2a_pkg::cw_t             cw;
  logic                     go;
  logic                     taken;

  assign cw = i2a_pkg::rom(pc_r);

  always_comb begin
    case (cw.op)
      i2a_pkg::OP_LOAD: go = in_tvalid;
      i2a_pkg::OP_SIGN: go = !stat.neg || stat.out_free;
      i2a_pkg::OP_EMIT: go = stat.out_free;
      default:          go = 1'b1;
    endcase
  end

  always_comb begin
    case (cw.cond)
      i2a_pkg::COND_NEVER:       taken = 1'b0;
      i2a_pkg::COND_ALWAYS:      taken = 1'b1;
      i2a_pkg::COND_BITS_MORE:   taken = stat.bits_more;
      i2a_pkg::COND_LEAD_ZERO:   taken = stat.lead_zero;
      i2a_pkg::COND_DIGITS_MORE: taken = stat.digits_more;
      default:                   taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      pc_nxt = taken ? cw.jmp : pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= i2a_pkg::ADDR_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op = cw.op;
  assign ctrl.go = go;

endmodule

@@ src/i2a_dp.sv @@
module i2a_dp #(
  parameter int VALUE_WIDTH = i2a_pkg::DEF_VALUE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  i2a_pkg::ctrl_t                     ctrl,
  input  logic [i2a_pkg::IN_TDATA_W-1:0]     in_tdata,
  output i2a_pkg::stat_t                     stat,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [i2a_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);

  // digits of 2**(VALUE_WIDTH-1), the largest magnitude
  localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int BC_W  = $clog2(VALUE_WIDTH + 1);
  localparam int ND_W  = $clog2(NDIG + 1);

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [BC_W-1:0]        bitcnt_r, bitcnt_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [ND_W-1:0]        ndig_r, ndig_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [i2a_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0] raw;
  logic [3:0]             top_digit;
  logic                   out_free;
  logic                   fire;

  assign raw       = in_tdata[VALUE_WIDTH-1:0];
  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = ctrl.go;

  always_comb begin
    for (int j = 0; j < NDIG; j++) begin
      bcd_adj[j*4 +: 4] = (bcd_r[j*4 +: 4] >= 4'd5) ? bcd_r[j*4 +: 4] + 4'd3
                                                   : bcd_r[j*4 +: 4];
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bitcnt_nxt    = bitcnt_r;
    bcd_nxt       = bcd_r;
    ndig_nxt      = ndig_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    if (fire) begin
      case (ctrl.op)
        i2a_pkg::OP_LOAD: begin
          neg_nxt    = raw[VALUE_WIDTH-1];
          mag_nxt    = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
          bitcnt_nxt = BC_W'(VALUE_WIDTH);
          bcd_nxt    = '0;
          ndig_nxt   = ND_W'(NDIG);
        end
        i2a_pkg::OP_SIGN: begin
          if (neg_r) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = i2a_pkg::CHAR_MINUS;
            out_last_nxt  = 1'b0;
          end
        end
        i2a_pkg::OP_DABBLE: begin
          bcd_nxt    = {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
          mag_nxt    = {mag_r[VALUE_WIDTH-2:0], 1'b0};
          bitcnt_nxt = bitcnt_r - 1'b1;
        end
        i2a_pkg::OP_SKIP: begin
          // drop a leading zero digit
          if (top_digit == 4'd0 && ndig_r != ND_W'(1)) begin
            bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
            ndig_nxt = ndig_r - 1'b1;
          end
        end
        i2a_pkg::OP_EMIT: begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = {i2a_pkg::CHAR_DIGIT_HI, top_digit};
          out_last_nxt  = (ndig_r == ND_W'(1));
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          ndig_nxt      = ndig_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bitcnt_r   <= bitcnt_nxt;
    bcd_r      <= bcd_nxt;
    ndig_r     <= ndig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign stat.neg         = neg_r;
  assign stat.out_free    = out_free;
  assign stat.bits_more   = (bitcnt_r != BC_W'(1));
  assign stat.lead_zero   = (top_digit == 4'd0) && (ndig_r != ND_W'(1));
  assign stat.digits_more = (ndig_r != ND_W'(1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(i2a_pkg::OUT_TDATA_W - i2a_pkg::CHAR_W){1'b0}}, out_char_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_mag_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == i2a_pkg::OP_SKIP) |-> (mag_r == '0))
    else $error("magnitude not fully shifted into BCD");

  a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == i2a_pkg::OP_EMIT) |-> (top_digit <= 4'd9))
    else $error("emitted digit is not decimal");

  a_ndig_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == i2a_pkg::OP_SKIP || ctrl.op == i2a_pkg::OP_EMIT) |-> (ndig_r != '0))
    else $error("digit count underflow");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_char_r == i2a_pkg::CHAR_MINUS) |-> !out_last_r)
    else $error("minus sign flagged as last");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == i2a_pkg::OP_EMIT && ctrl.go) |-> out_free)
    else $error("digit overwrote a pending character");
`endif

endmodule

@@ src/signed_int64_to_decimal_ascii.sv @@
// Channel | Dir | Ports                         | Payload
// in      | in  | in_tvalid/in_tready/in_tdata  | value, low VALUE_WIDTH bits used
// out     | out | out_tvalid/out_tready/out_tdata/out_tlast | char_code, last
//
// One value in flight. A value is converted by the one-bit-per-cycle binary to
// BCD shift, then leading zero digits are dropped and the characters are sent.
// Output stalls hold the sequencer on the sign and digit steps.
// Reset (rst_n low, synchronous) returns the sequencer to the load step and
// empties the output register.
module signed_int64_to_decimal_ascii #(
  parameter int VALUE_WIDTH = i2a_pkg::DEF_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [i2a_pkg::IN_TDATA_W-1:0]  in_tdata,   // [63:0] value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [i2a_pkg::OUT_TDATA_W-1:0] out_tdata,  // [5:0] char_code, [7:6] zero
  output logic                            out_tlast
);

  i2a_pkg::ctrl_t ctrl;
  i2a_pkg::stat_t stat;

  i2a_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  i2a_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_tdata   (in_tdata),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  assign in_tready = (ctrl.op == i2a_pkg::OP_LOAD);

endmodule
